### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ffqs_pkg.sv
// ----------------------------------------------------------------------------
// ffqs_pkg
// Types and constants shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ffqs_pkg;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 2;

    localparam logic [VALUE_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_SRCH = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

    typedef struct packed {
        logic               act;
        logic               hit;
        logic [VALUE_W-1:0] tgt;
    } srch_t;

endpackage

`default_nettype wire

### hdl/ffqs_cell.sv
// ----------------------------------------------------------------------------
// ffqs_cell
// One queue slot: holds an entry, shifts towards the head on a dequeue, takes
// a new entry when it is the first free slot, and passes the search word on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffqs_cell
    import ffqs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctl_t          ctl,
    input  wire logic [VALUE_W-1:0] enq_value,
    input  wire logic               prev_valid,
    input  wire logic [VALUE_W-1:0] next_data,
    input  wire logic               next_valid,
    input  wire srch_t              srch_in,
    output      logic [VALUE_W-1:0] data,
    output      logic               valid,
    output      srch_t              srch_out
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               valid_reg;
    logic               valid_next;
    logic               act_reg;
    logic               hit_reg;
    logic               hit_next;
    logic [VALUE_W-1:0] tgt_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.deq)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (ctl.enq && !valid_reg && prev_valid)
        begin
            data_next  = enq_value;
            valid_next = 1'b1;
        end
        hit_next = srch_in.hit || (valid_reg && (data_reg == srch_in.tgt));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            act_reg   <= srch_in.act;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
        tgt_reg  <= srch_in.tgt;
    end

    assign data         = data_reg;
    assign valid        = valid_reg;
    assign srch_out.act = act_reg;
    assign srch_out.hit = hit_reg;
    assign srch_out.tgt = tgt_reg;

    `ASSERT_IMPLIES(a_valid_contiguous, clk, rst_n, valid_reg, prev_valid,
        "Occupied slot follows a free slot.")

endmodule

`default_nettype wire

### hdl/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// First-in first-out queue of signed 32-bit words in a row of DEPTH cells.
// Enqueue, dequeue and no-op words return a registered result in the cycle after
// acceptance, and a new word may follow in the next cycle if m_tready is high.
// A search walks the chain of cells one cell per cycle; its result is registered
// once the search word leaves the last cell, and no word is taken in the meantime.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fifo_queue_with_search
    import ffqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // value
    input  wire logic [VALUE_W-1:0]  s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]   s_tuser,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // found, front_value, back_value, entry_count, error_code, zero padding
    output      logic [((1 + 2 * VALUE_W + $clog2(DEPTH + 1) + ERR_W + 7) / 8) * 8 - 1:0]
                                     m_tdata
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_BITS = 1 + 2 * VALUE_W + CNT_W + ERR_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [VALUE_W-1:0] back_reg;
    logic [VALUE_W-1:0] back_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic [OUT_W-1:0]   m_tdata_next;

    logic               in_fire;
    kind_t              in_kind;
    logic               full;
    logic               empty;
    logic               load;
    logic               found_res;
    err_t               err_res;
    logic [VALUE_W-1:0] front_res;
    logic [VALUE_W-1:0] back_res;
    cell_ctl_t          ctl;
    logic               launch;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    srch_t              srch_link [DEPTH + 1];

    assign in_kind  = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);

    assign srch_link[0].act = launch;
    assign srch_link[0].hit = 1'b0;
    assign srch_link[0].tgt = s_tdata;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               prev_valid;
        logic [VALUE_W-1:0] next_data;
        logic               next_valid;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_data  = cell_data[i];
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_data  = cell_data[i+1];
            assign next_valid = cell_valid[i+1];
        end

        ffqs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .enq_value  (s_tdata),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .srch_in    (srch_link[i]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .srch_out   (srch_link[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        back_next  = back_reg;
        ctl        = '0;
        launch     = 1'b0;
        load       = 1'b0;
        found_res  = 1'b0;
        err_res    = ERR_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_kind)
                        KIND_ENQ:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                err_res = ERR_FULL;
                            end
                            else
                            begin
                                ctl.enq   = 1'b1;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                back_next = s_tdata;
                            end
                        end
                        KIND_DEQ:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                err_res = ERR_EMPTY;
                            end
                            else
                            begin
                                ctl.deq  = 1'b1;
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        KIND_SRCH:
                        begin
                            launch     = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        KIND_NOP:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (srch_link[DEPTH].act)
                begin
                    load       = 1'b1;
                    found_res  = srch_link[DEPTH].hit;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (cnt_next == '0)
        begin
            front_res = EMPTY_MARK;
            back_res  = EMPTY_MARK;
        end
        else
        begin
            back_res = back_next;
            if (ctl.deq)
            begin
                front_res = cell_data[1];
            end
            else if (empty)
            begin
                front_res = s_tdata;
            end
            else
            begin
                front_res = cell_data[0];
            end
        end

        m_tdata_next  = load ? OUT_W'({err_res, cnt_next, back_res, front_res, found_res})
                             : m_tdata_reg;
        m_tvalid_next = load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg    <= back_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPLIES(a_count_matches_cells, clk, rst_n, 1'b1,
        $countones(cell_valid) == int'(cnt_reg), "Entry count disagrees with occupied cells.")
    `ASSERT_IMPLIES(a_search_done_in_search, clk, rst_n, srch_link[DEPTH].act,
        state_reg == ST_SEARCH, "Search result arrived outside a search.")
    `ASSERT_NEXT(a_search_launch, clk, rst_n, launch,
        (state_reg == ST_SEARCH) && !m_tvalid_reg, "Search launch did not enter the search.")

endmodule

`default_nettype wire
